FILE: sv/raidpq_pkg.sv
// Shared types and constants for the RAID P/Q parity accumulator.
// Holds the transaction payload structs, mode codes and the GF(2^8) product.
// No dependencies.
package raidpq_pkg;

    localparam int WordBits = 64;
    localparam int ByteBits = 8;
    localparam int IndexBits = 5;
    localparam int ModeBits = 3;

    localparam logic [ModeBits-1:0] MODE_P   = 3'd0;
    localparam logic [ModeBits-1:0] MODE_Q   = 3'd1;
    localparam logic [ModeBits-1:0] MODE_PQ  = 3'd2;
    localparam logic [ModeBits-1:0] MODE_RMW = 3'd3;
    localparam logic [ModeBits-1:0] MODE_QQ  = 3'd4;

    localparam logic [IndexBits-1:0] RMW_P_ONLY_SRC = 5'd2;
    localparam logic [IndexBits-1:0] RMW_Q_ONLY_SRC = 5'd3;
    localparam logic [IndexBits-1:0] RMW_BOTH_SRC   = 5'd4;

    localparam logic [ByteBits-1:0] GF_POLY_LOW = 8'h1D;

    typedef struct packed {
        logic [IndexBits-1:0] source_index;
        logic [WordBits-1:0]  data_word;
        logic [ByteBits-1:0]  coef_a;
        logic [ByteBits-1:0]  coef_b;
        logic                 last_source;
        logic                 last_column;
    } t_in_item;

    typedef struct packed {
        logic [WordBits-1:0] first_parity;
        logic [WordBits-1:0] second_parity;
        logic                stripe_end;
    } t_out_item;

    function automatic logic [ByteBits-1:0] gf_mul(input logic [ByteBits-1:0] x,
                                                   input logic [ByteBits-1:0] y);
        logic [ByteBits-1:0] acc;
        logic [ByteBits-1:0] m;
        acc = '0;
        m   = x;
        for (int b = 0; b < ByteBits; b++) begin
            if (y[b]) begin
                acc = acc ^ m;
            end
            m = m[ByteBits-1] ? ({m[ByteBits-2:0], 1'b0} ^ GF_POLY_LOW)
                              : {m[ByteBits-2:0], 1'b0};
        end
        return acc;
    endfunction

endpackage

FILE: sv/raidpq_word_scale.sv
// Byte-wise GF(2^8) scaling of one data word by a coefficient.
// Uses raidpq_pkg for widths and the field product.
module raidpq_word_scale #(
    parameter int WORD_BYTES = 8
) (
    input  logic [raidpq_pkg::WordBits-1:0] i_word,
    input  logic [raidpq_pkg::ByteBits-1:0] i_coef,
    output logic [raidpq_pkg::WordBits-1:0] o_word
);

    localparam int NumBytes = raidpq_pkg::WordBits / raidpq_pkg::ByteBits;

    for (genvar k = 0; k < NumBytes; k++) begin : g_byte
        if (k < WORD_BYTES) begin : g_used
            assign o_word[k*raidpq_pkg::ByteBits +: raidpq_pkg::ByteBits] =
                raidpq_pkg::gf_mul(i_coef,
                                   i_word[k*raidpq_pkg::ByteBits +: raidpq_pkg::ByteBits]);
        end else begin : g_unused
            assign o_word[k*raidpq_pkg::ByteBits +: raidpq_pkg::ByteBits] = '0;
        end
    end

endmodule

FILE: sv/raid_pq_parity_accumulator_unit.sv
// A transaction is registered at the input; when last_source is set, its result is registered
// in the output register once that transaction advances past any waiting result.
// Throughput: one transaction per cycle unless the input is stalled; the accumulate and GF multiply sit in one stage.
// A waiting result stalls the input only when the next transaction also ends a column.
// Reset (synchronous, active low) clears both accumulators, the mode and all valid flags.
// Depends on raidpq_pkg and raidpq_word_scale.
module raid_pq_parity_accumulator_unit #(
    parameter int MAX_SOURCES = 32,
    parameter int WORD_BYTES  = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [raidpq_pkg::ModeBits-1:0]  i_cfg_wr_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  raidpq_pkg::t_in_item             i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output raidpq_pkg::t_out_item            o_out_data
);

    localparam int W = raidpq_pkg::WordBits;
    localparam logic [8:0] MaxSrc = 9'(MAX_SOURCES);
    localparam logic [W-1:0] WordMask =
        (WORD_BYTES >= 8) ? {W{1'b1}} : ((W'(1) << (8 * WORD_BYTES)) - W'(1));

    logic [raidpq_pkg::ModeBits-1:0] r_mode;
    logic                            r_in_valid;
    raidpq_pkg::t_in_item            r_in;
    logic [W-1:0]                    r_acc_first;
    logic [W-1:0]                    r_acc_second;
    logic                            r_out_valid;
    raidpq_pkg::t_out_item           r_out;

    logic         accept;
    logic         advance;
    logic         in_range;
    logic         add_first;
    logic         add_second;
    logic [W-1:0] data_masked;
    logic [W-1:0] scale_a;
    logic [W-1:0] scale_b;
    logic [W-1:0] contrib_first;
    logic [W-1:0] contrib_second;
    logic [W-1:0] n_acc_first;
    logic [W-1:0] n_acc_second;

    assign data_masked = r_in.data_word & WordMask;

    raidpq_word_scale #(.WORD_BYTES(WORD_BYTES)) u_scale_a (
        .i_word (data_masked),
        .i_coef (r_in.coef_a),
        .o_word (scale_a)
    );

    raidpq_word_scale #(.WORD_BYTES(WORD_BYTES)) u_scale_b (
        .i_word (data_masked),
        .i_coef (r_in.coef_b),
        .o_word (scale_b)
    );

    assign in_range = {4'd0, r_in.source_index} < MaxSrc;

    always_comb begin
        add_first      = 1'b0;
        add_second     = 1'b0;
        contrib_first  = data_masked;
        contrib_second = scale_a;
        unique case (r_mode)
            raidpq_pkg::MODE_P: begin
                add_first = 1'b1;
            end
            raidpq_pkg::MODE_Q: begin
                add_second = 1'b1;
            end
            raidpq_pkg::MODE_PQ: begin
                add_first  = 1'b1;
                add_second = 1'b1;
            end
            raidpq_pkg::MODE_RMW: begin
                add_first  = (r_in.source_index == raidpq_pkg::RMW_P_ONLY_SRC) ||
                             (r_in.source_index >= raidpq_pkg::RMW_BOTH_SRC);
                add_second = r_in.source_index >= raidpq_pkg::RMW_Q_ONLY_SRC;
            end
            raidpq_pkg::MODE_QQ: begin
                add_first      = 1'b1;
                add_second     = 1'b1;
                contrib_first  = scale_a;
                contrib_second = scale_b;
            end
            default: begin
                add_first  = 1'b0;
                add_second = 1'b0;
            end
        endcase
        n_acc_first  = r_acc_first ^ ((add_first && in_range) ? contrib_first : '0);
        n_acc_second = r_acc_second ^ ((add_second && in_range) ? contrib_second : '0);
    end

    assign advance    = r_in_valid && (!r_in.last_source || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= raidpq_pkg::MODE_P;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_acc_first  <= '0;
            r_acc_second <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && r_in.last_source) begin
                r_out_valid  <= 1'b1;
                r_acc_first  <= '0;
                r_acc_second <= '0;
            end else begin
                if (!i_out_stall) begin
                    r_out_valid <= 1'b0;
                end
                if (advance) begin
                    r_acc_first  <= n_acc_first;
                    r_acc_second <= n_acc_second;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
        if (advance && r_in.last_source) begin
            if (r_mode == raidpq_pkg::MODE_Q) begin
                r_out.first_parity  <= n_acc_second;
                r_out.second_parity <= '0;
            end else begin
                r_out.first_parity  <= n_acc_first;
                r_out.second_parity <= n_acc_second;
            end
            r_out.stripe_end <= r_in.last_column;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.last_source |=> r_acc_first == '0 && r_acc_second == '0)
        else $error("Accumulators not cleared after a result was emitted.");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.last_source |=> o_out_valid)
        else $error("Column end did not produce a valid result.");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_in.last_source && r_out_valid)
        else $error("Input stalled without a blocked column end.");

    a_blocked_end_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall && r_in_valid && r_in.last_source |-> o_in_stall)
        else $error("Column end advanced over a waiting result.");
`endif

endmodule
